/* src/ers_pkg.sv */
// ----------------------------------------------------------------------------
// ers_pkg - shared types and constants of the EWMA rate selector
// Field widths, request and status codes, register indexes, fixed-point
// constants and the controller state type.
// ----------------------------------------------------------------------------
package ers_pkg;

  // Field widths
  localparam int MODE_W    = 2;
  localparam int ACTION_W  = 5;
  localparam int PHY_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int PROB_W    = 17;
  localparam int TPUT_W    = 32;
  localparam int PHASE_W   = 16;
  localparam int LFSR_W    = 16;
  localparam int NUM_W     = 5;
  localparam int ALPHA_W   = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 17;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_SELECT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REPORT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_SELECTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ACTIONS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EWMA_ALPHA     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED    = 2'd3;

  // Register reset values
  localparam logic [NUM_W-1:0]   NUM_ACTIONS_RST    = 5'd8;
  localparam logic [PHASE_W-1:0] PROBE_INTERVAL_RST = 16'd10;
  localparam logic [ALPHA_W-1:0] EWMA_ALPHA_RST     = 17'd16384;
  localparam logic [LFSR_W-1:0]  RANDOM_SEED_RST    = 16'd1;

  // Fixed point, Q1.16
  localparam logic [PROB_W-1:0] Q_ONE  = 17'd65536;
  localparam logic [PROB_W-1:0] Q_HALF = 17'd32768;

  // Galois LFSR taps
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPD_MUL,
    ST_UPD_WR,
    ST_EMIT
  } state_t;

endpackage

/* src/ers_in_if.sv */
// ----------------------------------------------------------------------------
// ers_in_if - request channel of the EWMA rate selector
// Valid/ready handshake carrying one request item.
// ----------------------------------------------------------------------------
interface ers_in_if;
  import ers_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [ACTION_W-1:0] action;
  logic                success;
  logic [PHY_W-1:0]    phy_rate;

  modport source (output valid, mode, action, success, phy_rate, input ready);
  modport sink   (input valid, mode, action, success, phy_rate, output ready);
endinterface

/* src/ers_out_if.sv */
// ----------------------------------------------------------------------------
// ers_out_if - result channel of the EWMA rate selector
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface ers_out_if;
  import ers_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ACTION_W-1:0] chosen_action;
  logic                probed;
  logic [TPUT_W-1:0]   best_throughput;

  modport source (output valid, status, chosen_action, probed, best_throughput,
                  input ready);
  modport sink   (input valid, status, chosen_action, probed, best_throughput,
                  output ready);
endinterface

/* src/ers_cfg_if.sv */
// ----------------------------------------------------------------------------
// ers_cfg_if - configuration write channel of the EWMA rate selector
// Valid/ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ers_cfg_if;
  import ers_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/ers_ram.sv */
// ----------------------------------------------------------------------------
// ers_ram - generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ers_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/ewma_rate_selector_unit.sv */
// ----------------------------------------------------------------------------
// ewma_rate_selector_unit - Minstrel-style transmit rate selector
// Keeps a success probability and a PHY rate per rate index in two small
// RAMs; answers select, outcome report and table load requests.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+------------------------------------------
//  in_req   | in  | valid / ready | mode, action, success, phy_rate
//  out_res  | out | valid / ready | status, chosen_action, probed,
//           |     |               | best_throughput
//  cfg_req  | in  | valid / ready | index, data (always ready)
//
//  Steps per request: a select scans the N rates in use, N being the rate
//  count in use, reading one RAM entry per cycle, followed by a multiply and
//  a compare stage; an outcome report reads, multiplies, accumulates and
//  writes back; load, probe and reject go straight to the emit state.
//  One request is in flight at a time, so RAM accesses never overlap.
//  Reset clears the probability valid bits at once; no clearing pass.
//  A finished result waits in the output register while the next request
//  is accepted; a second result holds in the emit state until that frees.
//
module ewma_rate_selector_unit #(
  parameter int MAX_ACTIONS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  ers_in_if.sink   in_req,
  ers_out_if.source out_res,
  ers_cfg_if.sink  cfg_req
);
  import ers_pkg::*;

  localparam int IW = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
  localparam int CW = $clog2(MAX_ACTIONS + 1);
  localparam int PW = LFSR_W + CW;

  // Configuration registers
  logic [NUM_W-1:0]   num_actions_r;
  logic [PHASE_W-1:0] probe_interval_r;
  logic [ALPHA_W-1:0] ewma_alpha_r;

  // Control state
  state_t             state_r, state_nxt;
  logic [PHASE_W-1:0] phase_r;
  logic [LFSR_W-1:0]  lfsr_r;
  logic [MAX_ACTIONS-1:0] prob_vld_r;
  logic [CW-1:0]      issue_r;
  logic               a_v_r, p_v_r;
  logic               out_valid_r;

  // Payload registers
  logic [IW-1:0]       a_idx_r, p_idx_r, k_r;
  logic [TPUT_W-1:0]   prod_r, best_r, best_nxt;
  logic [ACTION_W-1:0] pick_r, pick_nxt;
  logic                succ_r;
  logic [2*PROB_W-1:0] mul_r;
  logic [STATUS_W-1:0] res_status_r;
  logic [ACTION_W-1:0] res_action_r;
  logic                res_probed_r;
  logic [TPUT_W-1:0]   res_tput_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [ACTION_W-1:0] out_action_r;
  logic                out_probed_r;
  logic [TPUT_W-1:0]   out_tput_r;

  // Combinational
  logic [CW-1:0]       n_eff;
  logic [IW-1:0]       last_idx, k_in, rd_addr;
  logic                in_ready, in_acc, out_free, out_load;
  logic                is_sel, is_report, is_load, idx_ok, probe_now;
  logic                scan_rd, rd_en, scan_last;
  logic                rate_we, prob_we;
  logic [PHASE_W-1:0]  interval;
  logic [PHASE_W:0]    phase_inc;
  logic [LFSR_W-1:0]   lfsr_step;
  logic [PW-1:0]       probe_mul;
  logic [ACTION_W-1:0] probe_action;
  logic [PHY_W-1:0]    rate_rd;
  logic [PROB_W-1:0]   prob_rd, prob_scan, prob_upd, prob_wdata;
  logic [ALPHA_W-1:0]  alpha_sat;
  logic [PROB_W-1:0]   one_minus;
  logic [2*PROB_W-1:0] ewma_acc;
  logic [PHY_W+PROB_W-1:0] scan_prod;

  // ---------------------------------------------------------------------------
  // Configuration: always ready; a seed write reloads the LFSR (see below)
  // ---------------------------------------------------------------------------
  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_actions_r    <= NUM_ACTIONS_RST;
      probe_interval_r <= PROBE_INTERVAL_RST;
      ewma_alpha_r     <= EWMA_ALPHA_RST;
    end else if (cfg_req.valid) begin
      unique case (cfg_req.index)
        CFG_NUM_ACTIONS:    num_actions_r    <= cfg_req.data[NUM_W-1:0];
        CFG_PROBE_INTERVAL: probe_interval_r <= cfg_req.data[PHASE_W-1:0];
        CFG_EWMA_ALPHA:     ewma_alpha_r     <= cfg_req.data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the rate count to 1..MAX_ACTIONS
  always_comb begin
    if (num_actions_r == '0) begin
      n_eff = CW'(1);
    end else if (32'(num_actions_r) > MAX_ACTIONS) begin
      n_eff = CW'(MAX_ACTIONS);
    end else begin
      n_eff = CW'(num_actions_r);
    end
  end
  assign last_idx = IW'(n_eff - CW'(1));

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_req.valid && in_ready;
  assign is_sel    = (in_req.mode == MODE_SELECT);
  assign is_report = (in_req.mode == MODE_REPORT);
  assign is_load   = (in_req.mode == MODE_LOAD);
  assign idx_ok    = (in_req.action != '0) && (32'(in_req.action) <= 32'(n_eff));
  assign k_in      = IW'(in_req.action - ACTION_W'(1));

  // Probe decision: a zero interval acts as one
  assign interval  = (probe_interval_r == '0) ? PHASE_W'(1) : probe_interval_r;
  assign phase_inc = {1'b0, phase_r} + (PHASE_W+1)'(1);
  assign probe_now = (phase_inc >= {1'b0, interval});

  // Galois step and scaled pick of a random rate
  assign lfsr_step    = {1'b0, lfsr_r[LFSR_W-1:1]} ^ (lfsr_r[0] ? LFSR_TAPS : '0);
  assign probe_mul    = PW'(lfsr_step) * PW'(n_eff);
  assign probe_action = ACTION_W'(probe_mul >> LFSR_W) + ACTION_W'(1);

  // ---------------------------------------------------------------------------
  // Controller
  // ---------------------------------------------------------------------------
  assign out_free  = !out_valid_r || out_res.ready;
  assign scan_last = p_v_r && (p_idx_r == last_idx);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_sel && !probe_now) begin
            state_nxt = ST_SCAN;
          end else if (is_report && idx_ok) begin
            state_nxt = ST_UPD_MUL;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_UPD_MUL: state_nxt = ST_UPD_WR;
      ST_UPD_WR:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    scan_rd = (in_acc && is_sel && !probe_now) ||
              ((state_r == ST_SCAN) && (issue_r < n_eff));
    rd_en   = scan_rd || (in_acc && is_report && idx_ok);
    if (state_r == ST_SCAN) begin
      rd_addr = issue_r[IW-1:0];
    end else if (is_sel) begin
      rd_addr = '0;
    end else begin
      rd_addr = k_in;
    end
    rate_we  = in_acc && is_load && idx_ok;
    prob_we  = (state_r == ST_UPD_WR);
    out_load = (state_r == ST_EMIT) && out_free;
  end

  // ---------------------------------------------------------------------------
  // State memories
  // ---------------------------------------------------------------------------
  ers_ram #(.WIDTH(PHY_W), .DEPTH(MAX_ACTIONS)) u_rate_ram (
    .clk   (clk),
    .we    (rate_we),
    .waddr (k_in),
    .wdata (in_req.phy_rate),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rate_rd)
  );

  ers_ram #(.WIDTH(PROB_W), .DEPTH(MAX_ACTIONS)) u_prob_ram (
    .clk   (clk),
    .we    (prob_we),
    .waddr (k_r),
    .wdata (prob_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (prob_rd)
  );

  // An entry never reported on reads as one half
  assign prob_scan = prob_vld_r[a_idx_r] ? prob_rd : Q_HALF;
  assign prob_upd  = prob_vld_r[k_r] ? prob_rd : Q_HALF;

  // ---------------------------------------------------------------------------
  // Scan: read, multiply, compare; keep the first largest
  // ---------------------------------------------------------------------------
  assign scan_prod = (PHY_W+PROB_W)'(rate_rd) * (PHY_W+PROB_W)'(prob_scan);

  always_comb begin
    best_nxt = best_r;
    pick_nxt = pick_r;
    if (p_v_r && ((p_idx_r == '0) || (prod_r > best_r))) begin
      best_nxt = prod_r;
      pick_nxt = ACTION_W'(p_idx_r) + ACTION_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // EWMA: p' = ((1 - a) * p + a * s + 1/2) >> 16, alpha saturates at one
  // ---------------------------------------------------------------------------
  assign alpha_sat  = (ewma_alpha_r > Q_ONE) ? Q_ONE : ewma_alpha_r;
  assign one_minus  = Q_ONE - alpha_sat;
  assign ewma_acc   = mul_r + (succ_r ? ((2*PROB_W)'(alpha_sat) << 16) : '0)
                      + (2*PROB_W)'(Q_HALF);
  assign prob_wdata = ewma_acc[PROB_W+15:16];

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= '0;
      lfsr_r      <= RANDOM_SEED_RST;
      prob_vld_r  <= '0;
      issue_r     <= '0;
      a_v_r       <= 1'b0;
      p_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_v_r   <= scan_rd;
      p_v_r   <= a_v_r;

      // Seed write reloads the LFSR; a zero seed loads one
      if (cfg_req.valid && (cfg_req.index == CFG_RANDOM_SEED)) begin
        lfsr_r <= (cfg_req.data[LFSR_W-1:0] == '0) ? LFSR_W'(1)
                                                   : cfg_req.data[LFSR_W-1:0];
      end else if (in_acc && is_sel && probe_now) begin
        lfsr_r <= lfsr_step;
      end

      if (in_acc && is_sel) begin
        phase_r <= probe_now ? '0 : phase_inc[PHASE_W-1:0];
      end

      // Advance the scan read pointer
      if (in_acc) begin
        issue_r <= CW'(1);
      end else if (scan_rd) begin
        issue_r <= issue_r + CW'(1);
      end

      if (prob_we) begin
        prob_vld_r[k_r] <= 1'b1;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    a_idx_r <= rd_addr;
    p_idx_r <= a_idx_r;
    prod_r  <= scan_prod[TPUT_W-1:0];
    best_r  <= best_nxt;
    pick_r  <= pick_nxt;
    mul_r   <= (2*PROB_W)'(one_minus) * (2*PROB_W)'(prob_upd);

    if (in_acc) begin
      k_r          <= k_in;
      succ_r       <= in_req.success;
      res_status_r <= STATUS_REJECTED;
      res_action_r <= '0;
      res_probed_r <= 1'b0;
      res_tput_r   <= '0;
      unique case (in_req.mode)
        MODE_SELECT: begin
          res_status_r <= STATUS_SELECTED;
          if (probe_now) begin
            res_action_r <= probe_action;
            res_probed_r <= 1'b1;
          end
        end
        MODE_REPORT, MODE_LOAD: begin
          if (idx_ok) begin
            res_status_r <= STATUS_ACCEPTED;
          end
        end
        default: ;
      endcase
    end else if ((state_r == ST_SCAN) && scan_last) begin
      res_action_r <= pick_nxt;
      res_tput_r   <= best_nxt;
    end

    if (out_load) begin
      out_status_r <= res_status_r;
      out_action_r <= res_action_r;
      out_probed_r <= res_probed_r;
      out_tput_r   <= res_tput_r;
    end
  end

  assign in_req.ready            = in_ready;
  assign out_res.valid           = out_valid_r;
  assign out_res.status          = out_status_r;
  assign out_res.chosen_action   = out_action_r;
  assign out_res.probed          = out_probed_r;
  assign out_res.best_throughput = out_tput_r;

`ifndef SYNTHESIS
  a_prob_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    prob_we |-> (prob_wdata <= Q_ONE))
    else $error("probability write above one");

  a_scan_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_v_r |-> (CW'(p_idx_r) < n_eff))
    else $error("scan compare index beyond rate count");

  a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!a_v_r && !p_v_r))
    else $error("scan pipeline not empty when idle");

  a_probe_action: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_probed_r) |->
      ((res_action_r != '0) && (32'(res_action_r) <= 32'(n_eff))))
    else $error("probe rate outside rate count");

  a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("LFSR locked at zero");
`endif

endmodule

/* tb/ewma_rate_selector_unit_checker.sv */
// ----------------------------------------------------------------------------
// ewma_rate_selector_unit_checker - result predictor and scoreboard
// Watches the request, result and register write channels, keeps its own
// copy of the rate state, and compares every result with the oldest
// prediction in order.
// ----------------------------------------------------------------------------
module ewma_rate_selector_unit_checker #(
  parameter int MAX_ACTIONS = 16,
  parameter int MAX_PRINTS  = 100
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [ers_pkg::MODE_W-1:0]    in_mode,
  input  logic [ers_pkg::ACTION_W-1:0]  in_action,
  input  logic                          in_success,
  input  logic [ers_pkg::PHY_W-1:0]     in_phy_rate,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [ers_pkg::STATUS_W-1:0]  out_status,
  input  logic [ers_pkg::ACTION_W-1:0]  out_chosen_action,
  input  logic                          out_probed,
  input  logic [ers_pkg::TPUT_W-1:0]    out_best_throughput,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [ers_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ers_pkg::CFG_DAT_W-1:0] cfg_data,
  output int unsigned                   fail_count,
  output int unsigned                   pending
);
  import ers_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ACTION_W-1:0] chosen_action;
    logic                probed;
    logic [TPUT_W-1:0]   best_throughput;
  } rate_result_t;

  rate_result_t       expected_results[$];

  logic [PROB_W-1:0]  succ_prob [MAX_ACTIONS];
  logic [PHY_W-1:0]   phy_tbl   [MAX_ACTIONS];
  logic [PHASE_W-1:0] sel_phase;
  logic [LFSR_W-1:0]  probe_lfsr;
  logic [NUM_W-1:0]   num_reg;
  logic [PHASE_W-1:0] interval_reg;
  logic [ALPHA_W-1:0] alpha_reg;

  task automatic report_mismatch(string what, longint unsigned got,
                                 longint unsigned want);
    if (fail_count < MAX_PRINTS)
      $display("%0t ERROR: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Clamp the rate count register to 1..MAX_ACTIONS
  function automatic int unsigned rate_count();
    int unsigned n;
    n = num_reg;
    if (n < 1) n = 1;
    if (n > MAX_ACTIONS) n = MAX_ACTIONS;
    return n;
  endfunction

  function automatic void reload_lfsr(logic [LFSR_W-1:0] seed);
    probe_lfsr = (seed == '0) ? LFSR_W'(1) : seed;
  endfunction

  // Work out the result of one request and advance the rate state
  function automatic rate_result_t predict_rate(logic [MODE_W-1:0] mode,
                                                logic [ACTION_W-1:0] action,
                                                logic success,
                                                logic [PHY_W-1:0] phy);
    rate_result_t    res;
    int unsigned     n, interval, nxt, k;
    logic [LFSR_W-1:0] v;
    logic [TPUT_W-1:0] best, t;
    longint unsigned a, acc;
    n = rate_count();
    res = '0;
    res.status = STATUS_REJECTED;
    case (mode)
      MODE_SELECT: begin
        interval = (interval_reg == '0) ? 1 : interval_reg;
        nxt = sel_phase + 1;
        res.status = STATUS_SELECTED;
        if (nxt >= interval) begin
          // probe: step the Galois LFSR once and scale to the rate count
          v = probe_lfsr >> 1;
          if (probe_lfsr[0]) v = v ^ LFSR_TAPS;
          probe_lfsr = v;
          sel_phase = '0;
          res.chosen_action = ACTION_W'(((32'(v) * n) >> 16) + 1);
          res.probed = 1'b1;
        end else begin
          sel_phase = PHASE_W'(nxt);
          best = TPUT_W'(phy_tbl[0]) * TPUT_W'(succ_prob[0]);
          res.chosen_action = ACTION_W'(1);
          // first maximum wins, so compare strictly
          for (int i = 1; i < n; i++) begin
            t = TPUT_W'(phy_tbl[i]) * TPUT_W'(succ_prob[i]);
            if (t > best) begin
              best = t;
              res.chosen_action = ACTION_W'(i + 1);
            end
          end
          res.best_throughput = best;
        end
      end
      MODE_REPORT, MODE_LOAD: begin
        if (action >= 1 && action <= n) begin
          k = action - 1;
          if (mode == MODE_REPORT) begin
            a = (alpha_reg > Q_ONE) ? 64'(Q_ONE) : 64'(alpha_reg);
            acc = (64'd65536 - a) * 64'(succ_prob[k])
                + (success ? a * 64'd65536 : 64'd0) + 64'd32768;
            succ_prob[k] = PROB_W'(acc >> 16);
          end else begin
            phy_tbl[k] = phy;
          end
          res.status = STATUS_ACCEPTED;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    rate_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ACTIONS; i++) begin
        succ_prob[i] = Q_HALF;
        phy_tbl[i]   = '0;
      end
      sel_phase    = '0;
      num_reg      = NUM_ACTIONS_RST;
      interval_reg = PROBE_INTERVAL_RST;
      alpha_reg    = EWMA_ALPHA_RST;
      reload_lfsr(RANDOM_SEED_RST);
      expected_results.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NUM_ACTIONS:    num_reg      = cfg_data[NUM_W-1:0];
          CFG_PROBE_INTERVAL: interval_reg = cfg_data[PHASE_W-1:0];
          CFG_EWMA_ALPHA:     alpha_reg    = cfg_data[ALPHA_W-1:0];
          CFG_RANDOM_SEED:    reload_lfsr(cfg_data[LFSR_W-1:0]);
          default: ;
        endcase
      end
      // retire the result before taking a new request at the same edge
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request waiting", out_status, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_chosen_action !== want.chosen_action)
            report_mismatch("chosen_action", out_chosen_action,
                            want.chosen_action);
          if (out_probed !== want.probed)
            report_mismatch("probed", out_probed, want.probed);
          if (out_best_throughput !== want.best_throughput)
            report_mismatch("best_throughput", out_best_throughput,
                            want.best_throughput);
        end
      end
      if (in_valid && in_ready)
        expected_results.push_back(predict_rate(in_mode, in_action,
                                                in_success, in_phy_rate));
      pending <= expected_results.size();
    end
  end

endmodule

/* tb/ewma_rate_selector_unit_tb.sv */
// ----------------------------------------------------------------------------
// ewma_rate_selector_unit_tb - top of the rate selector testbench
// Drives directed and random select, report and load requests through
// several register settings with random idling on both channels; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module ewma_rate_selector_unit_tb;
  import ers_pkg::*;

  localparam int          CLK_PERIOD      = 10;
  localparam int          RESET_CYCLES    = 9;
  localparam int          MAX_ACTIONS     = 16;
  localparam int          PHASES          = 8;
  localparam int          ITEMS_PER_PHASE = 135;
  localparam int          IDLE_PCT        = 28;
  localparam int          HOLD_OFF_CYCLES = 300;
  // a full scan plus multiply, compare and emit stages
  localparam int          DRAIN_CYCLES    = MAX_ACTIONS + 8;
  localparam longint      TIMEOUT         = 64'd5_000_000;
  // the one mode the block has no use for
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        idle_on = 1'b1;
  int unsigned hold_off_req = 0;
  int unsigned rate_cnt = NUM_ACTIONS_RST;
  int unsigned fail_count;
  int unsigned pending;

  ers_in_if  in_req ();
  ers_out_if out_res ();
  ers_cfg_if cfg_req ();

  ewma_rate_selector_unit #(.MAX_ACTIONS(MAX_ACTIONS)) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_res (out_res),
    .cfg_req (cfg_req)
  );

  ewma_rate_selector_unit_checker #(.MAX_ACTIONS(MAX_ACTIONS)) i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_req.valid),
    .in_ready            (in_req.ready),
    .in_mode             (in_req.mode),
    .in_action           (in_req.action),
    .in_success          (in_req.success),
    .in_phy_rate         (in_req.phy_rate),
    .out_valid           (out_res.valid),
    .out_ready           (out_res.ready),
    .out_status          (out_res.status),
    .out_chosen_action   (out_res.chosen_action),
    .out_probed          (out_res.probed),
    .out_best_throughput (out_res.best_throughput),
    .cfg_valid           (cfg_req.valid),
    .cfg_ready           (cfg_req.ready),
    .cfg_index           (cfg_req.index),
    .cfg_data            (cfg_req.data),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case a handshake never completes
  initial begin
    #(TIMEOUT);
    $display("ewma_rate_selector_unit_tb: FAIL");
    $finish;
  end

  // Result side: drop ready at random, or hold it low for a long stretch
  // when the stimulus asks for one, so the block backs up into its input.
  initial begin
    int unsigned hold_off_seen;
    hold_off_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_off_seen != hold_off_req) begin
        hold_off_seen = hold_off_req;
        out_res.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_res.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // Offer one request, after a random gap, and hold it until accepted.
  // Leave valid high on return so a back-to-back request keeps it steady.
  task automatic send_req(logic [MODE_W-1:0] mode, logic [ACTION_W-1:0] action,
                          logic success, logic [PHY_W-1:0] phy);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_req.valid <= 1'b0;
      @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.mode     <= mode;
    in_req.action   <= action;
    in_req.success  <= success;
    in_req.phy_rate <= phy;
    do @(posedge clk); while (!in_req.ready);
  endtask

  // Register write; the caller drops cfg valid after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_req.valid <= 1'b1;
    cfg_req.index <= idx;
    cfg_req.data  <= data;
    do @(posedge clk); while (!cfg_req.ready);
  endtask

  // Stop offering requests and hold until every predicted result is back
  task automatic wait_drained();
    in_req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly well-formed selects, reports and loads on rates in use; the
  // rest are bad indexes and the unused mode.
  task automatic send_random();
    int unsigned           pick;
    logic [MODE_W-1:0]     mode;
    logic [ACTION_W-1:0]   action;
    logic [PHY_W-1:0]      phy;
    pick   = $urandom_range(0, 99);
    action = ACTION_W'($urandom_range(0, 31));
    phy    = PHY_W'($urandom_range(0, 65535));
    if (pick < 40) begin
      mode = MODE_SELECT;
    end else if (pick < 92) begin
      mode = (pick < 75) ? MODE_REPORT : MODE_LOAD;
      if ($urandom_range(0, 9) != 0) action = ACTION_W'($urandom_range(1, rate_cnt));
      case ($urandom_range(0, 7))
        0: phy = '0;
        1: phy = '1;
        default: ;
      endcase
    end else begin
      mode = MODE_UNUSED;
    end
    send_req(mode, action, 1'($urandom_range(0, 1)), phy);
  endtask

  // Short directed opener at reset settings (eight rates, probe every
  // tenth select): fill the rates in use first so no select ever scans an
  // entry that was never loaded.
  task automatic run_directed();
    for (int a = 1; a <= 8; a++)
      send_req(MODE_LOAD, ACTION_W'(a), 1'($urandom_range(0, 1)),
               (a == 1) ? 16'hFFFF : (a == 2) ? 16'h0000
                                              : PHY_W'($urandom_range(1, 65534)));
    // index zero and one past the rate count are rejected
    send_req(MODE_LOAD, 5'd0, 1'b1, 16'hFFFF);
    send_req(MODE_LOAD, 5'd9, 1'b0, 16'h1234);
    // top of the action field, then the unused mode with every bit set
    send_req(MODE_REPORT, 5'd31, 1'b1, 16'h0000);
    send_req(MODE_UNUSED, 5'd31, 1'b1, 16'hFFFF);
    send_req(MODE_REPORT, 5'd1, 1'b1, 16'h0000);
    send_req(MODE_REPORT, 5'd8, 1'b0, 16'hFFFF);
    send_req(MODE_REPORT, 5'd2, 1'b1, 16'h5A5A);
    // ten selects so the last one is a probe
    repeat (10)
      send_req(MODE_SELECT, ACTION_W'($urandom_range(0, 31)),
               1'($urandom_range(0, 1)), PHY_W'($urandom_range(0, 65535)));
  endtask

  // One register setting per phase: extremes first, random ones later.
  // Unused upper bits of the write data carry noise.
  task automatic configure_phase(int p);
    logic [NUM_W-1:0]     num;
    logic [PHASE_W-1:0]   intv;
    logic [ALPHA_W-1:0]   alpha;
    logic [LFSR_W-1:0]    seed;
    logic [CFG_DAT_W-1:0] noise;
    noise = CFG_DAT_W'($urandom_range(0, 131071));
    seed  = LFSR_W'($urandom_range(0, 65535));
    alpha = ALPHA_W'($urandom_range(0, 65536));
    intv  = PHASE_W'($urandom_range(1, 20));
    case (p)
      0: begin num = 5'd16; intv = 16'hFFFF; alpha = 17'd0;     seed = 16'h0000; end
      1: begin num = 5'd1;  intv = 16'd1;    alpha = Q_ONE;     seed = 16'h0001; end
      2: begin num = 5'd0;  intv = 16'd0;    alpha = 17'h1FFFF; seed = 16'hFFFF; end
      3: begin num = 5'd31; intv = 16'd3;    alpha = 17'd1;     seed = 16'hACE1; end
      4: begin num = 5'd5;  intv = 16'd7;    alpha = Q_HALF;                     end
      5: begin num = 5'd16; intv = 16'd2;    alpha = 17'hFFFF;                   end
      6: begin num = 5'd12; intv = 16'd10;                                       end
      default: num = 5'd16;
    endcase
    write_reg(CFG_NUM_ACTIONS, {noise[CFG_DAT_W-1:NUM_W], num});
    write_reg(CFG_PROBE_INTERVAL, {noise[CFG_DAT_W-1], intv});
    write_reg(CFG_EWMA_ALPHA, alpha);
    write_reg(CFG_RANDOM_SEED, {noise[CFG_DAT_W-2], seed});
    cfg_req.valid <= 1'b0;
    // track the clamped rate count to aim reports and loads
    rate_cnt = (num == 0) ? 1 : (num > MAX_ACTIONS) ? MAX_ACTIONS : num;
  endtask

  initial begin
    in_req.valid    = 1'b0;
    in_req.mode     = MODE_SELECT;
    in_req.action   = '0;
    in_req.success  = 1'b0;
    in_req.phy_rate = '0;
    out_res.ready   = 1'b0;
    cfg_req.valid   = 1'b0;
    cfg_req.index   = CFG_NUM_ACTIONS;
    cfg_req.data    = '0;
    rst_n           = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int p = 0; p < PHASES; p++) begin
      // registers change only with the block idle
      wait_drained();
      configure_phase(p);
      // first phase runs all sixteen rates: load the upper half of the table
      if (p == 0)
        for (int a = 9; a <= MAX_ACTIONS; a++)
          send_req(MODE_LOAD, ACTION_W'(a), 1'($urandom_range(0, 1)),
                   PHY_W'($urandom_range(0, 65535)));
      // one whole phase runs back to back on both sides
      idle_on = (p != 2);
      // stall the result side long enough to back up the request side
      if (p == 4) hold_off_req++;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // pause the request side once until the block has gone quiet
        if (p == 5 && i == ITEMS_PER_PHASE / 2) wait_drained();
        send_random();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("ewma_rate_selector_unit_tb: PASS");
    else
      $display("ewma_rate_selector_unit_tb: FAIL");
    $finish;
  end

endmodule
